@@ src/overwriting_message_ring_queue_core_defines.svh @@
// Assertion macros used by the ring queue sequencer.
`ifndef OVERWRITING_MESSAGE_RING_QUEUE_CORE_DEFINES_SVH
`define OVERWRITING_MESSAGE_RING_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked on aclk while aresetn is high.
`define OMRQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("omrq assertion failed");

// Next-cycle implication, checked on aclk while aresetn is high.
`define OMRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("omrq assertion failed");

`endif

@@ src/omrq_pkg.sv @@
// Shared types and constants of the message ring queue.
package omrq_pkg;

    localparam int OP_W     = 2;
    localparam int SRC_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int SIZE_W   = 6;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_NEWEST = 2'd2;
    localparam logic [OP_W-1:0] OP_SOURCE = 2'd3;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef struct packed {
        logic              found;
        logic [SRC_W-1:0]  src;
        logic [SIZE_W-1:0] size;
        logic [BYTE_W-1:0] data;
        logic              eor;
    } out_item_t;

    typedef struct packed {
        logic      direct;
        logic      issue;
        out_item_t item;
    } emit_t;

endpackage

@@ src/omrq_bytes.sv @@
// Message byte memory: one write port, one registered read port.
module omrq_bytes #(
    parameter int ADDR_W = 8
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [omrq_pkg::BYTE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [omrq_pkg::BYTE_W-1:0] rd_data
);
    import omrq_pkg::*;

    logic [BYTE_W-1:0] mem [2**ADDR_W];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/omrq_out_fifo.sv @@
// Four-entry result buffer in front of the master port.
module omrq_out_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  omrq_pkg::out_item_t           wr_item,
    output logic                          out_vld,
    input  logic                          out_rdy,
    output omrq_pkg::out_item_t           out_item,
    output logic [omrq_pkg::OUT_CNT_W-1:0] count
);
    import omrq_pkg::*;

    out_item_t              entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]   count_reg, count_next;
    logic                   pop;

    assign out_vld  = (count_reg != '0);
    assign pop      = out_vld && out_rdy;
    assign out_item = entry_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OUT_CNT_W'(wr_en) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

@@ src/omrq_ctrl.sv @@
// Queue sequencer: head/tail, push fill, slot metadata memory, read and search.
module omrq_ctrl #(
    parameter int QUEUE_DEPTH       = 8,
    parameter int MAX_MESSAGE_BYTES = 32,
    parameter int SW                = 3,
    parameter int BW                = 5,
    parameter int CW                = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_vld,
    output logic                        in_rdy,
    input  logic [omrq_pkg::OP_W-1:0]   op,
    input  logic [omrq_pkg::SRC_W-1:0]  source,
    input  logic [omrq_pkg::BYTE_W-1:0] data_byte,
    input  logic                        has_byte,
    input  logic                        last,
    input  logic                        room,
    output logic                        bw_en,
    output logic [SW+BW-1:0]            bw_addr,
    output logic [omrq_pkg::BYTE_W-1:0] bw_data,
    output logic                        br_en,
    output logic [SW+BW-1:0]            br_addr,
    output omrq_pkg::emit_t             emit
);
    import omrq_pkg::*;
    `include "overwriting_message_ring_queue_core_defines.svh"

    localparam int MW = SRC_W + CW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_META = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    function automatic logic [SW-1:0] step_fwd(input logic [SW-1:0] i);
        return (i == SW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [SW-1:0] step_back(input logic [SW-1:0] i);
        return (i == '0) ? SW'(QUEUE_DEPTH - 1) : i - 1'b1;
    endfunction

    logic [1:0]      state_reg, state_next;
    logic [SW-1:0]   head_reg, head_next;
    logic [SW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [SW-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   size_reg, size_next;
    logic [SRC_W-1:0] msrc_reg, msrc_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [SRC_W-1:0] src_reg, src_next;
    logic            empty_reg, empty_next;

    logic [MW-1:0]   meta_mem [QUEUE_DEPTH];
    logic [MW-1:0]   meta_rd_reg;
    logic            meta_we, meta_re;
    logic [SW-1:0]   meta_raddr;
    logic [MW-1:0]   meta_wdata;
    logic [SRC_W-1:0] meta_src;
    logic [CW-1:0]   meta_size;

    logic            acc, store, rd_end;
    logic [CW-1:0]   cnt_inc;
    logic [SW-1:0]   head_fwd;
    out_item_t       none_item;

    assign in_rdy    = (state_reg == ST_IDLE);
    assign acc       = in_vld && in_rdy;
    assign meta_src  = meta_rd_reg[MW-1 -: SRC_W];
    assign meta_size = meta_rd_reg[CW-1:0];
    assign store     = has_byte && (cnt_reg < CW'(MAX_MESSAGE_BYTES));
    assign cnt_inc   = cnt_reg + CW'(store);
    assign head_fwd  = step_fwd(head_reg);
    assign rd_end    = (k_reg == size_reg - 1'b1);
    assign bw_data   = data_byte;

    always_comb begin
        none_item     = '0;
        none_item.eor = 1'b1;
    end

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        k_next     = k_reg;
        size_next  = size_reg;
        msrc_next  = msrc_reg;
        op_next    = op_reg;
        src_next   = src_reg;
        empty_next = empty_reg;
        bw_en      = 1'b0;
        bw_addr    = {head_reg, cnt_reg[BW-1:0]};
        br_en      = 1'b0;
        br_addr    = {cur_reg, k_reg[BW-1:0]};
        meta_we    = 1'b0;
        meta_wdata = {source, cnt_inc};
        meta_re    = 1'b0;
        meta_raddr = cur_reg;
        emit       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (op == OP_PUSH) begin
                        bw_en = store;
                        if (last) begin
                            meta_we   = 1'b1;
                            cnt_next  = '0;
                            head_next = head_fwd;
                            if (head_fwd == tail_reg) begin
                                tail_next = step_fwd(tail_reg);
                            end
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end else begin
                        meta_re    = 1'b1;
                        meta_raddr = (op == OP_POP) ? tail_reg : step_back(head_reg);
                        cur_next   = meta_raddr;
                        op_next    = op;
                        src_next   = source;
                        empty_next = (head_reg == tail_reg);
                        state_next = ST_META;
                    end
                end
            end
            ST_META: begin
                priority if (empty_reg) begin
                    if (room) begin
                        emit.direct = 1'b1;
                        emit.item   = none_item;
                        state_next  = ST_IDLE;
                    end
                end else if (op_reg == OP_SOURCE && meta_src != src_reg) begin
                    if (cur_reg == tail_reg) begin
                        if (room) begin
                            emit.direct = 1'b1;
                            emit.item   = none_item;
                            state_next  = ST_IDLE;
                        end
                    end else begin
                        meta_re    = 1'b1;
                        meta_raddr = step_back(cur_reg);
                        cur_next   = meta_raddr;
                    end
                end else begin
                    tail_next  = (op_reg == OP_POP) ? step_fwd(tail_reg) : head_reg;
                    size_next  = meta_size;
                    msrc_next  = meta_src;
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                emit.item.found = 1'b1;
                emit.item.src   = msrc_reg;
                emit.item.size  = SIZE_W'(size_reg);
                if (room) begin
                    if (size_reg == '0) begin
                        emit.direct   = 1'b1;
                        emit.item.eor = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        br_en         = 1'b1;
                        emit.issue    = 1'b1;
                        emit.item.eor = rd_end;
                        k_next        = k_reg + 1'b1;
                        if (rd_end) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        k_reg     <= k_next;
        size_reg  <= size_next;
        msrc_reg  <= msrc_next;
        op_reg    <= op_next;
        src_reg   <= src_next;
        empty_reg <= empty_next;
    end

    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[head_reg] <= meta_wdata;
        end
        if (meta_re) begin
            meta_rd_reg <= meta_mem[meta_raddr];
        end
    end

    `OMRQ_ASSERT_NEXT(a_commit_nonempty, acc && op == OP_PUSH && last, head_reg != tail_reg)
    `OMRQ_ASSERT_NOW(a_direct_room, emit.direct, room)
    `OMRQ_ASSERT_NOW(a_issue_in_range, emit.issue, k_reg < size_reg)
    `OMRQ_ASSERT_NEXT(a_final_issue_idle, emit.issue && rd_end, state_reg == ST_IDLE)

endmodule

@@ src/overwriting_message_ring_queue_core.sv @@
// Top level of the overwriting message ring queue.
//
//   Port group  Direction  Carries
//   s_*         in         op / source / data_byte / has_byte / last, one item per transfer
//   m_*         out        found / msg_source / msg_size / out_byte / end_of_run
//
// Push items leave s_tready high; s_tready stays high between reads.
// A read holds s_tready low while it checks metadata slots (one for a pop, a newest read
// or an empty queue, up to QUEUE_DEPTH-1 for a source search), then while it reads each
// byte or emits one empty message; a not-found result leaves with the last slot check.
// aresetn clears head, tail, fill count and the result buffer; memories keep their contents.
// m_tready low fills the four-entry result buffer, which then stalls byte reads.
module overwriting_message_ring_queue_core #(
    parameter int QUEUE_DEPTH       = 8,
    parameter int MAX_MESSAGE_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // source[3:0], data_byte[11:4], zero[15:12]
    input  logic [2:0]  s_tuser,   // op[1:0], has_byte[2]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // msg_source[3:0], msg_size[9:4], out_byte[17:10], zero[23:18]
    output logic        m_tuser,   // found
    output logic        m_tlast
);
    import omrq_pkg::*;

    localparam int SW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int BW = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
    localparam int CW = $clog2(MAX_MESSAGE_BYTES + 1);

    logic                 bw_en, br_en, room, fifo_wr;
    logic [SW+BW-1:0]     bw_addr, br_addr;
    logic [BYTE_W-1:0]    bw_data, br_data;
    emit_t                emit;
    out_item_t            infl_item_reg, fifo_item, out_item;
    logic                 infl_vld_reg;
    logic [OUT_CNT_W-1:0] fifo_count;

    omrq_ctrl #(
        .QUEUE_DEPTH       (QUEUE_DEPTH),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
        .SW                (SW),
        .BW                (BW),
        .CW                (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_vld    (s_tvalid),
        .in_rdy    (s_tready),
        .op        (s_tuser[1:0]),
        .source    (s_tdata[3:0]),
        .data_byte (s_tdata[11:4]),
        .has_byte  (s_tuser[2]),
        .last      (s_tlast),
        .room      (room),
        .bw_en     (bw_en),
        .bw_addr   (bw_addr),
        .bw_data   (bw_data),
        .br_en     (br_en),
        .br_addr   (br_addr),
        .emit      (emit)
    );

    omrq_bytes #(
        .ADDR_W (SW + BW)
    ) u_bytes (
        .aclk    (aclk),
        .wr_en   (bw_en),
        .wr_addr (bw_addr),
        .wr_data (bw_data),
        .rd_en   (br_en),
        .rd_addr (br_addr),
        .rd_data (br_data)
    );

    assign room = (fifo_count + OUT_CNT_W'(infl_vld_reg)) < OUT_CNT_W'(OUT_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            infl_vld_reg <= 1'b0;
        end else begin
            infl_vld_reg <= emit.issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.issue) begin
            infl_item_reg <= emit.item;
        end
    end

    always_comb begin
        fifo_wr = infl_vld_reg || emit.direct;
        if (infl_vld_reg) begin
            fifo_item      = infl_item_reg;
            fifo_item.data = br_data;
        end else begin
            fifo_item = emit.item;
        end
    end

    omrq_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (fifo_wr),
        .wr_item  (fifo_item),
        .out_vld  (m_tvalid),
        .out_rdy  (m_tready),
        .out_item (out_item),
        .count    (fifo_count)
    );

    assign m_tdata = {6'b0, out_item.data, out_item.size, out_item.src};
    assign m_tuser = out_item.found;
    assign m_tlast = out_item.eor;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the overwriting message ring queue core.
module testbench;
    import omrq_pkg::*;

    localparam int QD          = 8;
    localparam int MAXB        = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 64;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    overwriting_message_ring_queue_core #(
        .QUEUE_DEPTH(QD),
        .MAX_MESSAGE_BYTES(MAXB)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // shadow copy of the ring
    logic [BYTE_W-1:0] ring_bytes [QD][MAXB];
    logic [SRC_W-1:0]  ring_src [QD];
    int                ring_size [QD];
    int                ring_head = 0;
    int                ring_tail = 0;
    int                fill_count = 0;

    out_item_t pending_results [$];

    int cycles = 0;
    int mismatches = 0;
    int pushes_sent = 0;
    int reads_sent = 0;
    int results_seen = 0;
    int not_found_reads = 0;
    int overwrites = 0;
    int dropped_bytes = 0;
    int src_gap_max = 18;
    int snk_gap_max = 18;
    bit hold_request = 1'b0;
    int hold_cycles = 0;
    logic [SRC_W-1:0] recent_src = '0;

    out_item_t got_item;
    out_item_t exp_item;

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("FAIL overwriting_message_ring_queue_core");
            $finish;
        end
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    function automatic string item_text(input out_item_t it);
        return $sformatf("found=%0d src=%0d size=%0d byte=%02h last=%0d",
                         it.found, it.src, it.size, it.data, it.eor);
    endfunction

    task automatic queue_result(input logic found, input logic [SRC_W-1:0] src,
                                input int size, input logic [BYTE_W-1:0] data,
                                input logic eor);
        out_item_t it;
        it.found = found;
        it.src   = src;
        it.size  = size[SIZE_W-1:0];
        it.data  = data;
        it.eor   = eor;
        pending_results.push_back(it);
    endtask

    // Advance the shadow ring by one accepted item and queue the results it causes.
    task automatic track_ring_item(input logic [OP_W-1:0] op, input logic [SRC_W-1:0] src,
                                   input logic [BYTE_W-1:0] dbyte, input logic has,
                                   input logic last);
        int slot;
        int k;
        slot = -1;
        if (op == OP_PUSH) begin
            pushes_sent++;
            if (has) begin
                if (fill_count < MAXB) begin
                    ring_bytes[ring_head][fill_count] = dbyte;
                    fill_count++;
                end else begin
                    dropped_bytes++;
                end
            end
            if (last) begin
                ring_src[ring_head]  = src;
                ring_size[ring_head] = fill_count;
                fill_count = 0;
                ring_head = (ring_head + 1) % QD;
                if (ring_head == ring_tail) begin
                    ring_tail = (ring_tail + 1) % QD;
                    overwrites++;
                end
            end
            return;
        end
        reads_sent++;
        if (ring_head != ring_tail) begin
            case (op)
                OP_POP: begin
                    slot = ring_tail;
                    ring_tail = (ring_tail + 1) % QD;
                end
                OP_NEWEST: begin
                    slot = (ring_head + QD - 1) % QD;
                    ring_tail = ring_head;
                end
                default: begin
                    k = ring_head;
                    while (k != ring_tail) begin
                        k = (k + QD - 1) % QD;
                        if (ring_src[k] == src) begin
                            slot = k;
                            ring_tail = ring_head;
                            break;
                        end
                    end
                end
            endcase
        end
        if (slot < 0) begin
            not_found_reads++;
            queue_result(1'b0, '0, 0, '0, 1'b1);
        end else if (ring_size[slot] == 0) begin
            queue_result(1'b1, ring_src[slot], 0, '0, 1'b1);
        end else begin
            for (k = 0; k < ring_size[slot]; k++)
                queue_result(1'b1, ring_src[slot], ring_size[slot], ring_bytes[slot][k],
                             k == ring_size[slot] - 1);
        end
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [SRC_W-1:0] src,
                             input logic [BYTE_W-1:0] dbyte, input logic has,
                             input logic last);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {4'b0000, dbyte, src};
        s_tuser  <= {has, op};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        track_ring_item(op, src, dbyte, has, last);
    endtask

    task automatic send_read(input logic [OP_W-1:0] op, input logic [SRC_W-1:0] src);
        send_item(op, src, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_message(input logic [SRC_W-1:0] src, input int len,
                                input bit mid_reads);
        int k;
        int op;
        if (len == 0) begin
            send_item(OP_PUSH, src, BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else begin
            for (k = 0; k < len; k++) begin
                if (mid_reads && $urandom_range(0, 19) == 0) begin
                    op = $urandom_range(1, 3);
                    send_read(op[OP_W-1:0], SRC_W'($urandom_range(0, 1) ? recent_src
                                                                 : $urandom_range(0, 15)));
                end
                send_item(OP_PUSH, (k == len - 1) ? src : SRC_W'($urandom_range(0, 15)),
                          BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 9) != 0,
                          k == len - 1);
            end
        end
        recent_src = src;
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic test_empty_reads();
        send_read(OP_POP, 4'd0);
        send_read(OP_NEWEST, 4'd15);
        send_read(OP_SOURCE, 4'd7);
    endtask

    task automatic test_message_forms();
        send_item(OP_PUSH, 4'd15, 8'h00, 1'b0, 1'b1);
        send_read(OP_POP, 4'd0);
        send_item(OP_PUSH, 4'd3, 8'h00, 1'b1, 1'b0);
        send_item(OP_PUSH, 4'd4, 8'hFF, 1'b1, 1'b0);
        send_item(OP_PUSH, 4'd5, 8'h12, 1'b0, 1'b0);
        send_item(OP_PUSH, 4'd0, 8'hA5, 1'b1, 1'b1);
    endtask

    task automatic test_read_during_push();
        send_item(OP_PUSH, 4'd6, 8'h5A, 1'b1, 1'b0);
        send_read(OP_SOURCE, 4'd0);
        send_read(OP_POP, 4'd0);
        send_item(OP_PUSH, 4'd9, 8'hC3, 1'b1, 1'b1);
        send_read(OP_SOURCE, 4'd3);
        send_read(OP_NEWEST, 4'd0);
    endtask

    task automatic test_overwrite();
        int k;
        for (k = 0; k < QD; k++)
            send_item(OP_PUSH, k[SRC_W-1:0], 8'h00, 1'b0, 1'b1);
        send_read(OP_POP, 4'd0);
        send_read(OP_SOURCE, 4'd4);
    endtask

    task automatic test_saturation();
        send_message(4'd15, MAXB + 8, 1'b0);
        send_read(OP_NEWEST, 4'd0);
        send_message(4'd1, MAXB, 1'b0);
        send_read(OP_SOURCE, 4'd1);
    endtask

    // Hold the result side off while the sender keeps feeding messages and reads.
    task automatic test_backpressure();
        int k;
        src_gap_max = 0;
        hold_cycles = 400;
        hold_request = 1'b1;
        for (k = 0; k < 4; k++)
            send_message(SRC_W'($urandom_range(0, 15)), 12, 1'b0);
        for (k = 0; k < 4; k++)
            send_read(OP_POP, 4'd0);
        send_message(4'd2, 3, 1'b0);
        src_gap_max = 18;
    endtask

    task automatic test_random(input int items, input int gap_max);
        int start;
        int len;
        int op;
        src_gap_max = gap_max;
        snk_gap_max = gap_max;
        start = pushes_sent + reads_sent;
        while (pushes_sent + reads_sent - start < items) begin
            if ($urandom_range(0, 99) < 70) begin
                case ($urandom_range(0, 19))
                    0:       len = $urandom_range(MAXB + 1, MAXB + 8);
                    1, 2, 3: len = $urandom_range(9, MAXB);
                    default: len = $urandom_range(0, 8);
                endcase
                send_message(SRC_W'($urandom_range(0, 15)), len, 1'b1);
            end else begin
                op = $urandom_range(1, 3);
                send_read(op[OP_W-1:0], SRC_W'($urandom_range(0, 2) != 0 ? recent_src
                                                                 : $urandom_range(0, 15)));
            end
        end
        src_gap_max = 18;
        snk_gap_max = 18;
    endtask

    initial begin : receiver
        int gap;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                gap = $urandom_range(0, snk_gap_max);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_item.found = m_tuser;
            got_item.src   = m_tdata[3:0];
            got_item.size  = m_tdata[9:4];
            got_item.data  = m_tdata[17:10];
            got_item.eor   = m_tlast;
            results_seen++;
            if (pending_results.size() == 0) begin
                note_mismatch({"unexpected transfer: ", item_text(got_item)});
            end else begin
                exp_item = pending_results.pop_front();
                if (got_item.found !== exp_item.found || got_item.src !== exp_item.src ||
                    got_item.size !== exp_item.size || got_item.data !== exp_item.data ||
                    got_item.eor !== exp_item.eor)
                    note_mismatch({"expected ", item_text(exp_item), ", got ",
                                   item_text(got_item)});
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_reads();
        test_message_forms();
        test_read_during_push();
        test_overwrite();
        test_saturation();
        test_backpressure();
        test_random(60, 18);
        test_random(30, 0);
        drop_valid();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        $display("covered %0d push items and %0d reads, %0d results checked",
                 pushes_sent, reads_sent, results_seen);
        $display("%0d empty or unmatched reads, %0d overwrites, %0d bytes past the size cap",
                 not_found_reads, overwrites, dropped_bytes);
        if (mismatches == 0)
            $display("PASS overwriting_message_ring_queue_core");
        else
            $display("FAIL overwriting_message_ring_queue_core");
        $finish;
    end

endmodule
